### hdl/tetrahedron_circumsphere_core_assert.svh
// Assertion macros shared by the circumsphere core RTL.
`ifndef TETRAHEDRON_CIRCUMSPHERE_CORE_ASSERT_SVH
`define TETRAHEDRON_CIRCUMSPHERE_CORE_ASSERT_SVH

// same-cycle implication
`define TCS_ASSERT_IMP(lbl, clk, rst_n, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

// fixed-delay implication
`define TCS_ASSERT_DLY(lbl, clk, rst_n, a, n, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> ##n (c)) else $error(msg);

`endif

### hdl/tcs_pkg.sv
// Package for the circumsphere core: word types and fixed constants.
`default_nettype none
package tcs_pkg;

  localparam int unsigned IN_BITS          = 16;
  localparam int unsigned CTR_BITS         = 40;
  localparam int unsigned RAD_BITS         = 64;
  localparam int unsigned TOL_BITS         = 20;
  localparam int unsigned TOL_SHIFT        = 52;
  localparam int unsigned RADIUS_FRAC      = 16;
  localparam int unsigned COORD_BITS_DEF   = 16;
  localparam int unsigned CENTER_FRAC_DEF  = 8;
  localparam logic [TOL_BITS-1:0] REL_TOL_RESET = 20'd100;

  typedef struct packed {
    logic signed [IN_BITS-1:0] a_x;
    logic signed [IN_BITS-1:0] a_y;
    logic signed [IN_BITS-1:0] a_z;
    logic signed [IN_BITS-1:0] b_x;
    logic signed [IN_BITS-1:0] b_y;
    logic signed [IN_BITS-1:0] b_z;
    logic signed [IN_BITS-1:0] c_x;
    logic signed [IN_BITS-1:0] c_y;
    logic signed [IN_BITS-1:0] c_z;
    logic signed [IN_BITS-1:0] d_x;
    logic signed [IN_BITS-1:0] d_y;
    logic signed [IN_BITS-1:0] d_z;
  } tcs_in_t;

  typedef struct packed {
    logic signed [CTR_BITS-1:0] center_x;
    logic signed [CTR_BITS-1:0] center_y;
    logic signed [CTR_BITS-1:0] center_z;
    logic        [RAD_BITS-1:0] radius_sq;
    logic                       degenerate;
  } tcs_out_t;

endpackage
`default_nettype wire

### hdl/tetrahedron_circumsphere_core.sv
// Circumsphere of a tetrahedron: fully pipelined center and squared radius.
//
// Usage:
//   An input word (four vertices, d is the reference) is taken on every rising
//   edge with start high; busy is always low, so one word per cycle is accepted.
//   Each result word appears on res_o with res_strobe_o high for one cycle.
//   Results leave in input order, one per input word.
//   The three restoring dividers give one quotient bit per stage
//   (4*COORD_BITS+26 stages), behind seven datapath stages and four output
//   stages (rounding, center sum and partial squares, axis squares, radius sum).
//   The receiver cannot stall; nothing is held back.
//   rel_tol is written with cfg_we_i/cfg_data_i while no word is in flight.
//   Reset clears all in-flight valid bits and sets rel_tol to 100.
//   Degenerate tets give degenerate=1 with center and radius zero.
`default_nettype none
module tetrahedron_circumsphere_core import tcs_pkg::*; #(
  parameter int unsigned COORD_BITS       = COORD_BITS_DEF,
  parameter int unsigned CENTER_FRAC_BITS = CENTER_FRAC_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [TOL_BITS-1:0] cfg_data_i,
  input  wire logic                start,
  input  wire tcs_in_t             in_word_i,
  output logic                     busy,
  output logic                     res_strobe_o,
  output tcs_out_t                 res_o
);

`include "tetrahedron_circumsphere_core_assert.svh"

  localparam int W    = COORD_BITS;
  localparam int D    = W + 1;
  localparam int SW   = 2 * D + 2;
  localparam int CPW  = 2 * D + 1;
  localparam int DTW  = D + CPW + 2;
  localparam int QW   = D + SW + 1;
  localparam int NB   = SW + CPW + 2;
  localparam int QB   = NB + RADIUS_FRAC + 1;
  localparam int MB   = DTW + 1;
  localparam int TW   = 3 * W + TOL_BITS;
  localparam int CMPW = (DTW > TW) ? DTW : TW;
  localparam int CW   = QB + 2;
  localparam int CFS  = RADIUS_FRAC - CENTER_FRAC_BITS;
  localparam int NST  = QB + 11;
  localparam int LAT  = QB + 11;

  function automatic logic signed [W-1:0] fld(logic [IN_BITS-1:0] f);
    logic [IN_BITS+W-1:0] z;
    z = {{W{f[IN_BITS-1]}}, f};
    return signed'(z[W-1:0]);
  endfunction

  function automatic logic [W-1:0] mag(logic signed [W-1:0] v);
    return v[W-1] ? (~v + 1'b1) : v;
  endfunction

  logic [TOL_BITS-1:0] rel_tol_q;
  logic [NST-1:0]      vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rel_tol_q <= REL_TOL_RESET;
      vld_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        rel_tol_q <= cfg_data_i;
      end
      vld_q <= {vld_q[NST-2:0], start};
    end
  end

  assign busy = 1'b0;

  // ---------------- stage 1: edge vectors, coordinate maxima
  logic signed [W-1:0] crd [12];
  logic signed [D-1:0] df_d [9];
  logic [W-1:0]        mx_d [3];

  always_comb begin
    crd[0]  = fld(in_word_i.a_x); crd[1]  = fld(in_word_i.a_y); crd[2]  = fld(in_word_i.a_z);
    crd[3]  = fld(in_word_i.b_x); crd[4]  = fld(in_word_i.b_y); crd[5]  = fld(in_word_i.b_z);
    crd[6]  = fld(in_word_i.c_x); crd[7]  = fld(in_word_i.c_y); crd[8]  = fld(in_word_i.c_z);
    crd[9]  = fld(in_word_i.d_x); crd[10] = fld(in_word_i.d_y); crd[11] = fld(in_word_i.d_z);
    for (int i = 0; i < 9; i++) begin
      df_d[i] = D'(crd[i]) - D'(crd[9 + (i % 3)]);
    end
    for (int j = 0; j < 3; j++) begin
      mx_d[j] = mag(crd[j]);
      for (int v = 1; v < 4; v++) begin
        if (mag(crd[3 * v + j]) > mx_d[j]) begin
          mx_d[j] = mag(crd[3 * v + j]);
        end
      end
    end
  end

  logic signed [D-1:0] df1_q [9];
  logic signed [W-1:0] dc1_q [3];
  logic [W-1:0]        mx1_q [3];

  always_ff @(posedge clk_i) begin
    df1_q <= df_d;
    mx1_q <= mx_d;
    for (int j = 0; j < 3; j++) begin
      dc1_q[j] <= crd[9 + j];
    end
  end

  // ---------------- stage 2: squares and cofactor products
  logic signed [2*D-1:0] sq2_q [9];
  logic signed [2*D-1:0] pp2_q [6];
  logic signed [D-1:0]   df2_q [9];
  logic signed [W-1:0]   dc2_q [3];
  logic [2*W-1:0]        t1_q;
  logic [W-1:0]          zm2_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 9; i++) begin
      sq2_q[i] <= (2*D)'(df1_q[i]) * (2*D)'(df1_q[i]);
    end
    pp2_q[0] <= (2*D)'(df1_q[4]) * (2*D)'(df1_q[8]);
    pp2_q[1] <= (2*D)'(df1_q[7]) * (2*D)'(df1_q[5]);
    pp2_q[2] <= (2*D)'(df1_q[7]) * (2*D)'(df1_q[2]);
    pp2_q[3] <= (2*D)'(df1_q[1]) * (2*D)'(df1_q[8]);
    pp2_q[4] <= (2*D)'(df1_q[1]) * (2*D)'(df1_q[5]);
    pp2_q[5] <= (2*D)'(df1_q[4]) * (2*D)'(df1_q[2]);
    t1_q     <= (2*W)'(mx1_q[0]) * (2*W)'(mx1_q[1]);
    zm2_q    <= mx1_q[2];
    df2_q    <= df1_q;
    dc2_q    <= dc1_q;
  end

  // ---------------- stage 3: squared lengths, cofactors
  logic signed [SW-1:0]  s3_q  [3];
  logic signed [CPW-1:0] cp3_q [3];
  logic signed [D-1:0]   df3_q [9];
  logic signed [W-1:0]   dc3_q [3];
  logic [3*W-1:0]        t2_q;

  always_ff @(posedge clk_i) begin
    for (int v = 0; v < 3; v++) begin
      s3_q[v]  <= SW'(sq2_q[3*v]) + SW'(sq2_q[3*v+1]) + SW'(sq2_q[3*v+2]);
      cp3_q[v] <= CPW'(pp2_q[2*v]) - CPW'(pp2_q[2*v+1]);
    end
    t2_q  <= (3*W)'(t1_q) * (3*W)'(zm2_q);
    df3_q <= df2_q;
    dc3_q <= dc2_q;
  end

  // ---------------- stage 4: det, Nx and q products, tolerance product
  logic signed [D+CPW-1:0]  detp4_q [3];
  logic signed [SW+CPW-1:0] nxp4_q  [3];
  logic signed [D+SW-1:0]   qp4_q   [6];
  logic signed [D-1:0]      df4_q   [9];
  logic signed [W-1:0]      dc4_q   [3];
  logic [TW-1:0]            t3_q;

  always_ff @(posedge clk_i) begin
    for (int v = 0; v < 3; v++) begin
      detp4_q[v] <= (D+CPW)'(df3_q[3*v]) * (D+CPW)'(cp3_q[v]);
      nxp4_q[v]  <= (SW+CPW)'(s3_q[v]) * (SW+CPW)'(cp3_q[v]);
    end
    qp4_q[0] <= (D+SW)'(df3_q[3]) * (D+SW)'(s3_q[2]);
    qp4_q[1] <= (D+SW)'(df3_q[6]) * (D+SW)'(s3_q[1]);
    qp4_q[2] <= (D+SW)'(df3_q[6]) * (D+SW)'(s3_q[0]);
    qp4_q[3] <= (D+SW)'(df3_q[0]) * (D+SW)'(s3_q[2]);
    qp4_q[4] <= (D+SW)'(df3_q[0]) * (D+SW)'(s3_q[1]);
    qp4_q[5] <= (D+SW)'(df3_q[3]) * (D+SW)'(s3_q[0]);
    t3_q     <= TW'(t2_q) * TW'(rel_tol_q);
    df4_q    <= df3_q;
    dc4_q    <= dc3_q;
  end

  // ---------------- stage 5: det, Nx, q sums, tolerance scale
  logic signed [DTW-1:0] det5_q;
  logic signed [NB-1:0]  nx5_q;
  logic signed [QW-1:0]  q5_q [3];
  logic [TW-1:0]         tol5_q;
  logic signed [D-1:0]   df5_q [9];
  logic signed [W-1:0]   dc5_q [3];

  always_ff @(posedge clk_i) begin
    det5_q <= DTW'(detp4_q[0]) + DTW'(detp4_q[1]) + DTW'(detp4_q[2]);
    nx5_q  <= NB'(nxp4_q[0]) + NB'(nxp4_q[1]) + NB'(nxp4_q[2]);
    for (int v = 0; v < 3; v++) begin
      q5_q[v] <= QW'(qp4_q[2*v]) - QW'(qp4_q[2*v+1]);
    end
    tol5_q <= t3_q >> TOL_SHIFT;
    df5_q  <= df4_q;
    dc5_q  <= dc4_q;
  end

  // ---------------- stage 6: Ny/Nz products, degeneracy, divisor
  logic [DTW-1:0] absdet;
  assign absdet = det5_q[DTW-1] ? DTW'(-det5_q) : DTW'(det5_q);

  logic signed [D+QW-1:0] nyp6_q [3];
  logic signed [D+QW-1:0] nzp6_q [3];
  logic signed [NB-1:0]   nx6_q;
  logic                   dgn6_q;
  logic                   dneg6_q;
  logic [MB-1:0]          dv6_q;
  logic signed [W-1:0]    dc6_q [3];

  always_ff @(posedge clk_i) begin
    for (int v = 0; v < 3; v++) begin
      nyp6_q[v] <= (D+QW)'(df5_q[3*v+2]) * (D+QW)'(q5_q[v]);
      nzp6_q[v] <= (D+QW)'(df5_q[3*v+1]) * (D+QW)'(q5_q[v]);
    end
    nx6_q   <= nx5_q;
    dgn6_q  <= CMPW'(absdet) <= CMPW'(tol5_q);
    dneg6_q <= det5_q[DTW-1];
    dv6_q   <= {absdet, 1'b0};
    dc6_q   <= dc5_q;
  end

  // ---------------- stage 7 and divider array (index 0 is stage 7)
  logic [MB-1:0]       rem_q [QB+1][3];
  logic [QB-1:0]       nq_q  [QB+1][3];
  logic [MB-1:0]       dv_q  [QB+1];
  logic [2:0]          neg_q [QB+1];
  logic                dgn_q [QB+1];
  logic signed [W-1:0] dcp_q [QB+1][3];

  logic signed [NB-1:0] n7 [3];
  always_comb begin
    n7[0] = nx6_q;
    n7[1] = NB'(nyp6_q[0]) + NB'(nyp6_q[1]) + NB'(nyp6_q[2]);
    n7[2] = -(NB'(nzp6_q[0]) + NB'(nzp6_q[1]) + NB'(nzp6_q[2]));
  end

  always_ff @(posedge clk_i) begin
    for (int v = 0; v < 3; v++) begin
      rem_q[0][v] <= '0;
      nq_q[0][v]  <= {(n7[v][NB-1] ? NB'(-n7[v]) : NB'(n7[v])), {(RADIUS_FRAC+1){1'b0}}};
      neg_q[0][v] <= n7[v][NB-1] ^ dneg6_q;
    end
    dv_q[0]  <= dv6_q;
    dgn_q[0] <= dgn6_q;
    dcp_q[0] <= dc6_q;
  end

  // one quotient bit per stage, restoring
  for (genvar k = 1; k <= QB; k++) begin : g_div
    for (genvar v = 0; v < 3; v++) begin : g_ax
      logic [MB:0] trial;
      logic        ge;
      assign trial = {rem_q[k-1][v], nq_q[k-1][v][QB-1]};
      assign ge    = trial >= {1'b0, dv_q[k-1]};
      always_ff @(posedge clk_i) begin
        rem_q[k][v] <= ge ? MB'(trial - {1'b0, dv_q[k-1]}) : trial[MB-1:0];
        nq_q[k][v]  <= {nq_q[k-1][v][QB-2:0], ge};
      end
    end
    always_ff @(posedge clk_i) begin
      dv_q[k]  <= dv_q[k-1];
      neg_q[k] <= neg_q[k-1];
      dgn_q[k] <= dgn_q[k-1];
      dcp_q[k] <= dcp_q[k-1];
    end
  end

  // ---------------- post 1: round to radius and center precision
  logic [QB-1:0]       q16_1_q [3];
  logic [QB-1:0]       qf_1_q  [3];
  logic [2:0]          neg1_q;
  logic                dgn1_q;
  logic signed [W-1:0] dc1p_q [3];
  logic [QB-1:0]       qs [3];

  always_comb begin
    for (int v = 0; v < 3; v++) begin
      qs[v] = nq_q[QB][v] >> CFS;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int v = 0; v < 3; v++) begin
      q16_1_q[v] <= QB'(({1'b0, nq_q[QB][v]} + 1'b1) >> 1);
      qf_1_q[v]  <= QB'(({1'b0, qs[v]} + 1'b1) >> 1);
    end
    neg1_q <= neg_q[QB];
    dgn1_q <= dgn_q[QB];
    dc1p_q <= dcp_q[QB];
  end

  // ---------------- post 2: center offset add and clamp, partial squares
  logic signed [CW-1:0] cf [3];
  logic signed [CW-1:0] csum [3];
  logic [CTR_BITS-1:0]  csat [3];

  always_comb begin
    for (int v = 0; v < 3; v++) begin
      cf[v]   = neg1_q[v] ? -signed'(CW'(qf_1_q[v])) : signed'(CW'(qf_1_q[v]));
      csum[v] = cf[v] + (CW'(dc1p_q[v]) <<< CENTER_FRAC_BITS);
      if (csum[v][CW-1:CTR_BITS-1] != {(CW-CTR_BITS+1){csum[v][CW-1]}}) begin
        csat[v] = csum[v][CW-1] ? {1'b1, {(CTR_BITS-1){1'b0}}} : {1'b0, {(CTR_BITS-1){1'b1}}};
      end else begin
        csat[v] = csum[v][CTR_BITS-1:0];
      end
    end
  end

  logic [CTR_BITS-1:0] ctr2_q [3];
  logic [2:0]          big2_q;
  logic [15:0]         hh2_q [3];
  logic [39:0]         hl2_q [3];
  logic [63:0]         ll2_q [3];
  logic                dgn2_q;

  always_ff @(posedge clk_i) begin
    for (int v = 0; v < 3; v++) begin
      ctr2_q[v] <= csat[v];
      big2_q[v] <= |q16_1_q[v][QB-1:40];
      hh2_q[v]  <= 16'(q16_1_q[v][39:32]) * 16'(q16_1_q[v][39:32]);
      hl2_q[v]  <= 40'(q16_1_q[v][39:32]) * 40'(q16_1_q[v][31:0]);
      ll2_q[v]  <= 64'(q16_1_q[v][31:0]) * 64'(q16_1_q[v][31:0]);
    end
    dgn2_q <= dgn1_q;
  end

  // ---------------- post 3: per-axis squares
  logic [79:0]         sq3_q [3];
  logic                sat3_q;
  logic                dgn3_q;
  logic [CTR_BITS-1:0] ctr3_q [3];

  always_ff @(posedge clk_i) begin
    for (int v = 0; v < 3; v++) begin
      sq3_q[v] <= {hh2_q[v], 64'd0} + (80'(hl2_q[v]) << 33) + 80'(ll2_q[v]);
    end
    sat3_q <= |big2_q;
    dgn3_q <= dgn2_q;
    ctr3_q <= ctr2_q;
  end

  // ---------------- post 4: radius sum, round, clamp, output word
  logic [81:0] rsum;
  logic        rsat;
  assign rsum = 82'(sq3_q[0]) + 82'(sq3_q[1]) + 82'(sq3_q[2]) + 82'(1 << (RADIUS_FRAC - 1));
  assign rsat = sat3_q | (|rsum[81:80]);

  tcs_out_t res_q;
  always_ff @(posedge clk_i) begin
    if (dgn3_q) begin
      res_q <= '{center_x: '0, center_y: '0, center_z: '0, radius_sq: '0, degenerate: 1'b1};
    end else begin
      res_q.center_x   <= ctr3_q[0];
      res_q.center_y   <= ctr3_q[1];
      res_q.center_z   <= ctr3_q[2];
      res_q.radius_sq  <= rsat ? '1 : rsum[79:16];
      res_q.degenerate <= 1'b0;
    end
  end

  assign res_o        = res_q;
  assign res_strobe_o = vld_q[NST-1];

  // ---------------- checks
  `TCS_ASSERT_DLY(a_latency, clk_i, rst_ni, start, LAT, res_strobe_o, "result word missing")
  `TCS_ASSERT_IMP(a_degen_zero, clk_i, rst_ni, res_strobe_o && res_o.degenerate, res_o.center_x == '0 && res_o.center_y == '0 && res_o.center_z == '0 && res_o.radius_sq == '0, "degenerate word not zeroed")
  `TCS_ASSERT_IMP(a_rem_bound, clk_i, rst_ni, vld_q[6+QB] && (dv_q[QB] != '0), rem_q[QB][0] < dv_q[QB] && rem_q[QB][1] < dv_q[QB] && rem_q[QB][2] < dv_q[QB], "divider remainder out of range")

endmodule
`default_nettype wire

### verif/tetrahedron_circumsphere_core_test.sv
// Self-checking testbench for the tetrahedron circumsphere core.
`timescale 1ns / 1ps
module tetrahedron_circumsphere_core_test;
  import tcs_pkg::*;

  typedef logic signed [191:0] wide_t;
  typedef logic [191:0] wide_u;

  localparam int unsigned LATENCY = 4 * COORD_BITS_DEF + 36;
  localparam int unsigned STALL_LIMIT = 4000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [TOL_BITS-1:0] cfg_data_i = '0;
  logic start = 1'b0;
  tcs_in_t in_word_i = '0;
  logic busy;
  logic res_strobe_o;
  tcs_out_t res_o;

  tcs_in_t tet_queue[$];
  tcs_out_t sphere_queue[$];
  logic [TOL_BITS-1:0] tol_reg = REL_TOL_RESET;
  int unsigned mismatches = 0;
  int unsigned words_in = 0;
  int unsigned words_out = 0;
  int unsigned flat_seen = 0;
  int unsigned sat_seen = 0;
  int unsigned idle_cycles = 0;
  int unsigned gap_left = 0;
  bit no_gaps = 1'b0;
  bit stim_done = 1'b0;

  always #5 clk_i = ~clk_i;

  tetrahedron_circumsphere_core i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .start        (start),
    .in_word_i    (in_word_i),
    .busy         (busy),
    .res_strobe_o (res_strobe_o),
    .res_o        (res_o)
  );

  // round(num * 2^sh / den), ties away from zero
  function automatic wide_t div_nearest(wide_t num, int sh, wide_t den);
    wide_u an, ad, q, r;
    an = (num < 0) ? -num : num;
    ad = (den < 0) ? -den : den;
    an = an << sh;
    q = an / ad;
    r = an % ad;
    if ((r << 1) >= ad) q = q + 1;
    return ((num < 0) != (den < 0)) ? -wide_t'(q) : wide_t'(q);
  endfunction

  function automatic wide_t abs_max4(wide_t p, wide_t q, wide_t r, wide_t s);
    wide_t v[4];
    wide_t m;
    v[0] = p; v[1] = q; v[2] = r; v[3] = s;
    m = 0;
    foreach (v[i]) begin
      if (v[i] < 0) v[i] = -v[i];
      if (v[i] > m) m = v[i];
    end
    return m;
  endfunction

  function automatic tcs_out_t sphere_of(tcs_in_t w);
    wide_t ax, ay, az, bx, by, bz, cx, cy, cz, dx, dy, dz;
    wide_t dax, day, daz, dbx, dby, dbz, dcx, dcy, dcz;
    wide_t sa, sb, sc, cpa, cpb, cpc, det, tol, qa, qb, qc, den, c, o, sum;
    wide_t n[3];
    wide_t d[3];
    wide_t lim;
    bit sat;
    tcs_out_t res;
    ax = w.a_x; ay = w.a_y; az = w.a_z; bx = w.b_x; by = w.b_y; bz = w.b_z;
    cx = w.c_x; cy = w.c_y; cz = w.c_z; dx = w.d_x; dy = w.d_y; dz = w.d_z;
    dax = ax - dx; day = ay - dy; daz = az - dz;
    dbx = bx - dx; dby = by - dy; dbz = bz - dz;
    dcx = cx - dx; dcy = cy - dy; dcz = cz - dz;
    sa = dax * dax + day * day + daz * daz;
    sb = dbx * dbx + dby * dby + dbz * dbz;
    sc = dcx * dcx + dcy * dcy + dcz * dcz;
    cpa = dby * dcz - dcy * dbz;
    cpb = dcy * daz - day * dcz;
    cpc = day * dbz - dby * daz;
    det = dax * cpa + dbx * cpb + dcx * cpc;
    tol = abs_max4(ax, bx, cx, dx) * abs_max4(ay, by, cy, dy) * abs_max4(az, bz, cz, dz)
          * wide_t'(tol_reg);
    tol = tol >>> TOL_SHIFT;
    res = '0;
    if (((det < 0) ? -det : det) <= tol) begin
      res.degenerate = 1'b1;
      return res;
    end
    qa = dbx * sc - dcx * sb;
    qb = dcx * sa - dax * sc;
    qc = dax * sb - dbx * sa;
    n[0] = sa * cpa + sb * cpb + sc * cpc;
    n[1] = daz * qa + dbz * qb + dcz * qc;
    n[2] = -(day * qa + dby * qb + dcy * qc);
    d[0] = dx; d[1] = dy; d[2] = dz;
    den = det * 2;
    lim = (wide_t'(1) <<< (CTR_BITS - 1)) - 1;
    sum = 0;
    sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      c = div_nearest(n[i], CENTER_FRAC_DEF, den) + (d[i] <<< CENTER_FRAC_DEF);
      if (c > lim) c = lim;
      else if (c < -lim - 1) c = -lim - 1;
      o = div_nearest(n[i], RADIUS_FRAC, den);
      if (o < 0) o = -o;
      if (o >= (wide_t'(1) <<< 63)) sat = 1'b1;
      else sum = sum + o * o;
      if (i == 0) res.center_x = c[CTR_BITS-1:0];
      if (i == 1) res.center_y = c[CTR_BITS-1:0];
      if (i == 2) res.center_z = c[CTR_BITS-1:0];
    end
    if (!sat) begin
      sum = (sum + (wide_t'(1) <<< (RADIUS_FRAC - 1))) >>> RADIUS_FRAC;
      if (sum >= (wide_t'(1) <<< RAD_BITS)) sat = 1'b1;
    end
    res.radius_sq = sat ? '1 : sum[RAD_BITS-1:0];
    return res;
  endfunction

  task automatic report_mismatch(string what);
    mismatches++;
    $display("mismatch @%0t: %s", $time, what);
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  // driver: word accepted at an edge with start high and busy low
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        sphere_queue.push_back(sphere_of(tet_queue.pop_front()));
        words_in++;
        gap_left = pick_gap();
      end else if (gap_left > 0) begin
        gap_left--;
      end
      if (gap_left == 0 && tet_queue.size() > 0) begin
        start <= 1'b1;
        in_word_i <= tet_queue[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    tcs_out_t exp_w;
    if (rst_ni && res_strobe_o) begin
      words_out++;
      if (sphere_queue.size() == 0) begin
        report_mismatch("result word with nothing expected");
      end else begin
        exp_w = sphere_queue.pop_front();
        if (res_o.degenerate) flat_seen++;
        if (res_o.radius_sq == '1) sat_seen++;
        if (res_o.center_x !== exp_w.center_x)
          report_mismatch($sformatf("center_x %0d exp %0d", res_o.center_x, exp_w.center_x));
        if (res_o.center_y !== exp_w.center_y)
          report_mismatch($sformatf("center_y %0d exp %0d", res_o.center_y, exp_w.center_y));
        if (res_o.center_z !== exp_w.center_z)
          report_mismatch($sformatf("center_z %0d exp %0d", res_o.center_z, exp_w.center_z));
        if (res_o.radius_sq !== exp_w.radius_sq)
          report_mismatch($sformatf("radius_sq %0d exp %0d", res_o.radius_sq,
                                    exp_w.radius_sq));
        if (res_o.degenerate !== exp_w.degenerate)
          report_mismatch($sformatf("degenerate %0b exp %0b", res_o.degenerate,
                                    exp_w.degenerate));
      end
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || res_strobe_o) idle_cycles = 0;
      else if (!stim_done) idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog expired after %0d idle cycles", idle_cycles);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  function automatic tcs_in_t make_tet(int v[12]);
    tcs_in_t w;
    w.a_x = v[0]; w.a_y = v[1]; w.a_z = v[2];
    w.b_x = v[3]; w.b_y = v[4]; w.b_z = v[5];
    w.c_x = v[6]; w.c_y = v[7]; w.c_z = v[8];
    w.d_x = v[9]; w.d_y = v[10]; w.d_z = v[11];
    return w;
  endfunction

  function automatic int clamp16(int v);
    return (v > 32767) ? 32767 : (v < -32768) ? -32768 : v;
  endfunction

  function automatic tcs_in_t random_tet();
    int v[12];
    int span, base, k;
    k = $urandom_range(0, 9);
    if (k < 4) begin
      foreach (v[i]) v[i] = $signed(16'($urandom));
    end else if (k < 8) begin
      // each vertex jittered around its own random point, wide range of jitter sizes
      span = 1 << $urandom_range(0, 14);
      foreach (v[i]) begin
        if (i % 3 == 0) base = $signed(16'($urandom));
        v[i] = clamp16(base + $urandom_range(0, 2 * span) - span);
      end
    end else begin
      // nearly flat: c on the plane through d of a, b, then nudged
      foreach (v[i]) v[i] = $signed(16'($urandom)) / 4;
      for (int j = 0; j < 3; j++)
        v[6 + j] = clamp16(v[j] + v[3 + j] - v[9 + j] + $urandom_range(0, 2) - 1);
    end
    return make_tet(v);
  endfunction

  task automatic write_tol(logic [TOL_BITS-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= val;
    tol_reg = val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    while (tet_queue.size() > 0 || sphere_queue.size() > 0) @(negedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  initial begin
    int dir[12][12] = '{
      '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{1, 0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0},
      '{1, 0, 0, 0, 1, 0, 1, 1, 0, 0, 0, 0},
      '{32767, 0, 0, 0, 32767, 0, 0, 0, 32767, -32768, -32768, -32768},
      '{-32768, -32768, -32768, 32767, 32767, -32768, 32767, -32768, 32767,
        -32768, 32767, 32767},
      '{-32768, -32768, 0, 32767, -32768, 0, 0, 32767, 0, 0, 0, 1},
      '{32767, 32767, 32767, 32766, 32767, 32767, 32767, 32766, 32767,
        32767, 32767, 32766},
      '{-32768, 0, 0, 32767, 0, 0, 0, 1, 0, 0, 0, 1},
      '{3, 1, 4, 1, 5, 9, 2, 6, 5, 3, 5, 8},
      '{100, 0, 0, -100, 0, 0, 0, 100, 0, 0, 0, 100},
      '{-1, -1, -1, 1, 1, -1, 1, -1, 1, -1, 1, 1},
      '{-32768, -32768, -32768, -32767, -32768, -32768, -32768, -32767, -32768,
        -32768, -32768, -32767}
    };
    logic [TOL_BITS-1:0] tols[5];
    tols[0] = 20'd100; tols[1] = '0; tols[2] = '1;
    tols[3] = 20'($urandom); tols[4] = 20'($urandom_range(1, 4000));
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    foreach (dir[i]) tet_queue.push_back(make_tet(dir[i]));
    foreach (tols[p]) begin
      drain();
      write_tol(tols[p]);
      @(negedge clk_i);
      no_gaps = (p == 1);
      if (p == 0)
        foreach (dir[i]) tet_queue.push_back(make_tet(dir[i]));
      repeat (350) tet_queue.push_back(random_tet());
    end
    drain();
    stim_done = 1'b1;
    $display("%0d tetrahedra in, %0d results out over 5 tolerance settings", words_in,
             words_out);
    $display("%0d flat within tolerance, %0d with saturated radius", flat_seen, sat_seen);
    if (mismatches == 0 && sphere_queue.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### files.f
+incdir+hdl
hdl/tcs_pkg.sv
hdl/tetrahedron_circumsphere_core.sv
verif/tetrahedron_circumsphere_core_test.sv
